// ===== hw/rtl/vtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and codes for the vertex transform / project unit.
// ----------------------------------------------------------------------------
package vtp_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_POINT   = 2'd1,
    OP_PROJECT = 2'd2,
    OP_DIR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOT  = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  localparam int unsigned LANES = 3;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic start;
    logic with_t;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vtp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_lane
// One dot-product lane: three products and translation, floor shift, clamp.
// Two-stage: products registered, then sum/shift/saturate registered.
// ----------------------------------------------------------------------------
module vtp_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire vtp_pkg::lane_ctl_t ctl,
  input  wire signed [31:0]   x,
  input  wire signed [31:0]   y,
  input  wire signed [31:0]   z,
  input  wire signed [31:0]   m0,
  input  wire signed [31:0]   m1,
  input  wire signed [31:0]   m2,
  input  wire signed [31:0]   mt,
  output logic signed [31:0]  res,
  output logic                sat
);
  localparam int unsigned SW = 66 + FRAC_BITS;

  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [31:0] t_r;
  logic signed [SW-1:0] sum;
  logic signed [SW-FRAC_BITS-1:0] shv;
  logic signed [31:0] res_nxt;
  logic sat_nxt;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p0_r <= x * m0;
      p1_r <= y * m1;
      p2_r <= z * m2;
      t_r  <= ctl.with_t ? mt : 32'sd0;
    end
    res <= res_nxt;
    sat <= sat_nxt;
  end

  always_comb begin
    sum = SW'(p0_r) + SW'(p1_r) + SW'(p2_r) + (SW'(t_r) <<< FRAC_BITS);
    shv = sum[SW-1:FRAC_BITS];
    if (shv > (SW-FRAC_BITS)'(64'sh7FFFFFFF)) begin
      res_nxt = 32'sh7FFFFFFF; sat_nxt = 1'b1;
    end else if (shv < -(SW-FRAC_BITS)'(64'sh80000000)) begin
      res_nxt = 32'sh80000000; sat_nxt = 1'b1;
    end else begin
      res_nxt = shv[31:0]; sat_nxt = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vtp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_div
// Radix-2 signed divider: (n << FRAC_BITS) / d truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtp_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [31:0] n,
  input  wire signed [31:0] d,
  output logic              busy,
  output logic signed [31:0] q,
  output logic              sat
);
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, quo_r;
  logic [32:0]   rem_r;
  logic [31:0]   den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [33:0]   trial;
  logic [NW:0]   mag;
  logic [NW:0]   lim;

  assign trial = {rem_r, num_r[NW-1]} - {2'b0, den_r};
  assign busy  = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      num_r <= NW'(n[31] ? -{{FRAC_BITS{1'b0}}, n} : {{FRAC_BITS{1'b0}}, n}) << FRAC_BITS;
      den_r <= d[31] ? -d : d;
      neg_r <= n[31] ^ d[31];
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CW'(NW);
    end else if (busy) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], num_r[NW-1]};
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
      num_r <= num_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_comb begin
    mag = {1'b0, quo_r};
    lim = neg_r ? (NW+1)'(64'h80000000) : (NW+1)'(64'h7FFFFFFF);
    if (mag > lim) begin
      sat = 1'b1;
      q   = neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      sat = 1'b0;
      q   = neg_r ? -quo_r[31:0] : quo_r[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vertex_transform_project_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_project_unit
// 4x4 row-vector transform of Q(FRAC_BITS) vectors with perspective divide.
// ----------------------------------------------------------------------------
// Input word (in_valid/in_stall): a load word writes one matrix entry and
// yields nothing. A transform word runs four lanes (x, y, z, w dot products)
// side by side: products registered, then sum and clamp registered. A
// projection with nonzero w then runs three radix-2 dividers together for
// 32+FRAC_BITS quotient bits (48 at Q16.16), one quotient bit per cycle; the
// divider loop sets the rate. Point/direction/zero-w projection: the word
// passes ST_DOT, then ST_OUT. Projection with nonzero w: ST_DOT, ST_DIV, then
// ST_OUT. One word is in flight at a time; receiver stalls hold it in ST_OUT.
// Output word (out_valid/out_stall): held in an output register until taken;
// in_stall stays high while it waits. Reset loads the identity matrix and
// empties the pipeline.
// ----------------------------------------------------------------------------
module vertex_transform_project_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire [1:0]         in_operation,
  input  wire [3:0]         in_entry_index,
  input  wire signed [31:0] in_entry_value,
  input  wire signed [31:0] in_x_in,
  input  wire signed [31:0] in_y_in,
  input  wire signed [31:0] in_z_in,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_z_out,
  output logic              out_w_was_zero,
  output logic              out_saturated
);
  // matrix, reset to identity
  logic signed [31:0] mat_r [16];
  vtp_pkg::state_t state_r, state_nxt;
  logic [1:0] dcnt_r;
  logic proj_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic signed [31:0] lres [4];
  logic lsat [4];
  logic div_busy [3];
  logic signed [31:0] dq [3];
  logic dsat [3];
  logic dsat_r;
  logic wz_r;
  logic accept, go, div_start, wzero;
  vtp_pkg::lane_ctl_t ctl;

  assign accept = in_valid && !in_stall;
  assign go = accept && (vtp_pkg::op_t'(in_operation) != vtp_pkg::OP_LOAD);
  assign wzero = (lres[3] == 32'sd0);

  always_comb begin
    in_stall = (state_r != vtp_pkg::ST_IDLE);
    ctl.start = go;
    ctl.with_t = (vtp_pkg::op_t'(in_operation) != vtp_pkg::OP_DIR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++)
        mat_r[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    end else if (accept && vtp_pkg::op_t'(in_operation) == vtp_pkg::OP_LOAD) begin
      mat_r[in_entry_index] <= in_entry_value;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      vtp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .ctl(ctl), .x(in_x_in), .y(in_y_in), .z(in_z_in),
        .m0(mat_r[g]), .m1(mat_r[4+g]), .m2(mat_r[8+g]), .mt(mat_r[12+g]),
        .res(lres[g]), .sat(lsat[g]));
    end
    for (g = 0; g < vtp_pkg::LANES; g++) begin : g_div
      vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .n(lres[g]), .d(lres[3]),
        .busy(div_busy[g]), .q(dq[g]), .sat(dsat[g]));
    end
  endgenerate

  // lane results are valid in ST_DOT once dcnt_r reaches 1
  assign div_start = (state_r == vtp_pkg::ST_DOT) && (dcnt_r == 2'd1) && proj_r && !wzero;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vtp_pkg::ST_IDLE: if (go) state_nxt = vtp_pkg::ST_DOT;
      vtp_pkg::ST_DOT:  if (dcnt_r == 2'd1)
                          state_nxt = div_start ? vtp_pkg::ST_DIV : vtp_pkg::ST_OUT;
      vtp_pkg::ST_DIV:  if (!div_busy[0]) state_nxt = vtp_pkg::ST_OUT;
      vtp_pkg::ST_OUT:  if (!out_stall) state_nxt = vtp_pkg::ST_IDLE;
      default:          state_nxt = vtp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state_r == vtp_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vtp_pkg::ST_IDLE;
      dcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (go) dcnt_r <= 2'd0;
      else if (state_r == vtp_pkg::ST_DOT) dcnt_r <= dcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) proj_r <= (vtp_pkg::op_t'(in_operation) == vtp_pkg::OP_PROJECT);
    if (state_r == vtp_pkg::ST_DOT && dcnt_r == 2'd1) begin
      vx_r <= lres[0];
      vy_r <= lres[1];
      vz_r <= lres[2];
      wz_r <= proj_r && wzero;
      dsat_r <= lsat[0] | lsat[1] | lsat[2] | (proj_r & lsat[3]);
    end
    if (state_r == vtp_pkg::ST_DIV && !div_busy[0]) begin
      vx_r <= dq[0];
      vy_r <= dq[1];
      vz_r <= dq[2];
      dsat_r <= dsat_r | dsat[0] | dsat[1] | dsat[2];
    end
  end

  assign out_x_out = vx_r;
  assign out_y_out = vy_r;
  assign out_z_out = vz_r;
  assign out_w_was_zero = wz_r;
  assign out_saturated = dsat_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != vtp_pkg::ST_IDLE) |-> !accept) else $error("accept while busy");
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy[0] == div_busy[1]) && (div_busy[1] == div_busy[2]))
    else $error("dividers out of step");
  a_div_only_proj: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> proj_r) else $error("divide without projection");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_out) && $stable(out_y_out)
      && $stable(out_z_out) && $stable(out_w_was_zero) && $stable(out_saturated))
    else $error("output dropped");
endmodule
`default_nettype wire
